// ----- src/ap2d_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ap2d_pkg
// Shared types, constants and helpers of the 2-D average pooling block.
// ----------------------------------------------------------------------------
package ap2d_pkg;

	// Register field widths
	localparam int IMG_W_BITS   = 11;
	localparam int IMG_H_BITS   = 11;
	localparam int WIN_BITS     = 4;
	localparam int SCALE_BITS   = 17;
	localparam int PLANE_BITS   = 16;
	localparam int CFG_IDX_BITS = 3;
	localparam int CFG_DATA_BITS = 17;

	// Compare width for position checks (holds every limit plus one)
	localparam int CMP_W = 17;

	// Fraction bits of the reciprocal
	localparam int FRAC_BITS = 16;

	// Parameter defaults
	localparam int MAX_WIDTH_DEF   = 1024;
	localparam int MAX_WINDOW_DEF  = 8;
	localparam int SAMPLE_BITS_DEF = 16;

	// Queue depths (powers of two)
	localparam int MID_DEPTH = 4;
	localparam int OUT_DEPTH = 8;

	// Reset values of the registers
	localparam logic [IMG_W_BITS-1:0] IMG_W_RST   = 11'd2;
	localparam logic [IMG_H_BITS-1:0] IMG_H_RST   = 11'd2;
	localparam logic [WIN_BITS-1:0]   WIN_W_RST   = 4'd2;
	localparam logic [WIN_BITS-1:0]   WIN_H_RST   = 4'd2;
	localparam logic [SCALE_BITS-1:0] SCALE_RST   = 17'd16384;
	localparam logic [PLANE_BITS-1:0] PLANE_T_RST = 16'd1;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_IMAGE_WIDTH   = 3'd0,
		CFG_IMAGE_HEIGHT  = 3'd1,
		CFG_WINDOW_WIDTH  = 3'd2,
		CFG_WINDOW_HEIGHT = 3'd3,
		CFG_SCALE_RECIP   = 3'd4,
		CFG_PLANE_TOTAL   = 3'd5
	} cfg_reg_e;

	// Plane geometry as handed to the front end
	typedef struct packed {
		logic [IMG_W_BITS-1:0] image_width;
		logic [IMG_H_BITS-1:0] image_height;
		logic [WIN_BITS-1:0]   window_width;
		logic [WIN_BITS-1:0]   window_height;
		logic [PLANE_BITS-1:0] plane_total;
	} geom_t;

	// Per-sample classification from the front end
	typedef struct packed {
		logic first;      // first sample of this window: sum restarts
		logic emit;       // window complete, produce a result
		logic plane_done;
		logic job_done;
	} ctl_t;

	localparam int CTL_BITS = $bits(ctl_t);

	// Zero acts as 1, anything above hi acts as hi
	function automatic logic [CMP_W-1:0] clamp_val(input logic [CMP_W-1:0] v,
		input logic [CMP_W-1:0] hi);
		logic [CMP_W-1:0] r;
		if (v == '0) begin
			r = {{(CMP_W-1){1'b0}}, 1'b1};
		end else if (v > hi) begin
			r = hi;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

// ----- src/ap2d_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ap2d_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ap2d_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// read returns the old contents on a same-address collision
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- src/ap2d_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ap2d_fifo
// Small register FIFO with occupancy count; first-word fall-through.
// ----------------------------------------------------------------------------
module ap2d_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [WIDTH-1:0]           wdata,
	input  logic                       pop,
	output logic [WIDTH-1:0]           rdata,
	output logic                       empty,
	output logic                       full,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int AW = $clog2(DEPTH);
	localparam int NW = $clog2(DEPTH+1);

	logic [WIDTH-1:0] data_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [NW-1:0]    count_q;
	logic             do_push, do_pop;

	assign do_push = push && (count_q != NW'(DEPTH));
	assign do_pop  = pop && (count_q != '0);

	always_ff @(posedge clk) begin
		if (do_push) begin
			data_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + NW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

	assign rdata = data_q[rd_ptr_q];
	assign empty = (count_q == '0);
	assign full  = (count_q == NW'(DEPTH));
	assign count = count_q;

endmodule

// ----- src/ap2d_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ap2d_front
// Raster position tracking: tags each accepted sample with its line-store
// column and window flags.
// ----------------------------------------------------------------------------
module ap2d_front #(
	parameter int MAX_WIDTH   = ap2d_pkg::MAX_WIDTH_DEF,
	parameter int MAX_WINDOW  = ap2d_pkg::MAX_WINDOW_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         take,
	input  ap2d_pkg::geom_t              geom,
	output logic [$clog2(MAX_WIDTH)-1:0] slot,
	output ap2d_pkg::ctl_t               ctl
);
	import ap2d_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WINDOW);

	logic [CW-1:0]         col_pos_q, out_col_q;
	logic [WW-1:0]         col_win_q, row_win_q;
	logic [IMG_H_BITS-1:0] row_pos_q;
	logic [PLANE_BITS-1:0] plane_q;

	logic [CMP_W-1:0] iw, ih, ww, wh, pt;
	logic last_col_in_win, last_col, last_row_in_win, last_row, last_plane;

	always_comb begin
		iw = clamp_val(CMP_W'(geom.image_width), CMP_W'(MAX_WIDTH));
		ih = clamp_val(CMP_W'(geom.image_height), CMP_W'(2**IMG_H_BITS - 1));
		ww = clamp_val(CMP_W'(geom.window_width), CMP_W'(MAX_WINDOW));
		wh = clamp_val(CMP_W'(geom.window_height), CMP_W'(MAX_WINDOW));
		pt = clamp_val(CMP_W'(geom.plane_total), CMP_W'(2**PLANE_BITS - 1));

		last_col_in_win = (CMP_W'(col_win_q) + CMP_W'(1)) >= ww;
		last_col        = (CMP_W'(col_pos_q) + CMP_W'(1)) >= iw;
		last_row_in_win = (CMP_W'(row_win_q) + CMP_W'(1)) >= wh;
		last_row        = (CMP_W'(row_pos_q) + CMP_W'(1)) >= ih;
		last_plane      = (CMP_W'(plane_q) + CMP_W'(1)) >= pt;

		slot           = out_col_q;
		ctl.first      = (row_win_q == '0) && (col_win_q == '0);
		// cut-off windows close on the last column or the last row
		ctl.emit       = (last_col_in_win || last_col) && (last_row_in_win || last_row);
		ctl.plane_done = last_col && last_row;
		ctl.job_done   = last_col && last_row && last_plane;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_pos_q <= '0;
			out_col_q <= '0;
			col_win_q <= '0;
			row_win_q <= '0;
			row_pos_q <= '0;
			plane_q   <= '0;
		end else if (take) begin
			if (last_col) begin
				col_pos_q <= '0;
				col_win_q <= '0;
				out_col_q <= '0;
				if (last_row) begin
					row_pos_q <= '0;
					row_win_q <= '0;
					plane_q   <= last_plane ? '0 : plane_q + PLANE_BITS'(1);
				end else begin
					row_pos_q <= row_pos_q + IMG_H_BITS'(1);
					row_win_q <= last_row_in_win ? '0 : row_win_q + WW'(1);
				end
			end else begin
				col_pos_q <= col_pos_q + CW'(1);
				if (last_col_in_win) begin
					col_win_q <= '0;
					out_col_q <= out_col_q + CW'(1);
				end else begin
					col_win_q <= col_win_q + WW'(1);
				end
			end
		end
	end

endmodule

// ----- src/ap2d_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ap2d_back
// Line-store accumulate, reciprocal multiply, round and saturate, and the
// result queue.
// ----------------------------------------------------------------------------
module ap2d_back #(
	parameter int MAX_WIDTH   = ap2d_pkg::MAX_WIDTH_DEF,
	parameter int MAX_WINDOW  = ap2d_pkg::MAX_WINDOW_DEF,
	parameter int SAMPLE_BITS = ap2d_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 q_valid,
	input  logic signed [SAMPLE_BITS-1:0]        q_sample,
	input  logic [$clog2(MAX_WIDTH)-1:0]         q_slot,
	input  ap2d_pkg::ctl_t                       q_ctl,
	output logic                                 q_pop,
	input  logic [ap2d_pkg::SCALE_BITS-1:0]      scale_recip,
	output logic                                 empty,
	input  logic                                 pop,
	output logic signed [SAMPLE_BITS-1:0]        average,
	output logic                                 plane_done,
	output logic                                 job_done
);
	import ap2d_pkg::*;

	localparam int CW     = $clog2(MAX_WIDTH);
	localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_WINDOW * MAX_WINDOW);
	localparam int PROD_W = SUM_W + SCALE_BITS + 1;
	localparam int RND_W  = PROD_W + 1;
	localparam int RW     = RND_W - FRAC_BITS;
	localparam int ON_W   = $clog2(OUT_DEPTH + 1);
	localparam int CR_W   = $clog2(OUT_DEPTH + 4) + 1;
	localparam int OW     = SAMPLE_BITS + 2;

	localparam logic signed [RW-1:0] SAT_HI =
		RW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
	localparam logic signed [RW-1:0] SAT_LO = -SAT_HI - RW'(1);
	localparam logic signed [RND_W-1:0] ROUND_HALF = RND_W'(64'sd1 <<< (FRAC_BITS - 1));

	// stage 1: line-store data back, accumulate and write
	logic                          v_s1;
	logic signed [SAMPLE_BITS-1:0] sample_s1;
	logic [CW-1:0]                 slot_s1;
	ctl_t                          ctl_s1;
	// stage 2: multiply
	logic                          v_s2;
	logic [CW-1:0]                 slot_s2;
	logic signed [SUM_W-1:0]       sum_s2;
	ctl_t                          ctl_s2;
	// stage 3: round, saturate
	logic                          v_s3;
	logic signed [PROD_W-1:0]      prod_s3;
	ctl_t                          ctl_s3;

	logic [SUM_W-1:0]        rd_data;
	logic signed [SUM_W-1:0] base, sum;
	logic signed [RND_W-1:0] rounded;
	logic signed [RW-1:0]    scaled;
	logic signed [SAMPLE_BITS-1:0] avg_sat;
	logic [ON_W-1:0]         out_count;
	logic [CR_W-1:0]         pending;
	logic                    out_push;
	logic [OW-1:0]           out_rdata;

	// hold an item back unless the result queue can absorb everything in flight
	assign pending = CR_W'(out_count) + CR_W'(v_s1) + CR_W'(v_s2) + CR_W'(v_s3) + CR_W'(1);
	assign q_pop   = q_valid && (pending <= CR_W'(OUT_DEPTH));

	ap2d_ram #(
		.WIDTH(SUM_W),
		.DEPTH(MAX_WIDTH)
	) u_line_store (
		.clk  (clk),
		.we   (v_s1),
		.waddr(slot_s1),
		.wdata(sum),
		.raddr(q_slot),
		.rdata(rd_data)
	);

	always_comb begin
		// previous beat's write collided with this beat's read: bypass it
		if (ctl_s1.first) begin
			base = '0;
		end else if (v_s2 && (slot_s2 == slot_s1)) begin
			base = sum_s2;
		end else begin
			base = $signed(rd_data);
		end
		sum = base + SUM_W'(sample_s1);
	end

	always_comb begin
		rounded = RND_W'(prod_s3) + ROUND_HALF;
		scaled  = RW'(rounded >>> FRAC_BITS);
		if (scaled > SAT_HI) begin
			avg_sat = SAMPLE_BITS'(SAT_HI);
		end else if (scaled < SAT_LO) begin
			avg_sat = SAMPLE_BITS'(SAT_LO);
		end else begin
			avg_sat = SAMPLE_BITS'(scaled);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= q_pop;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		sample_s1 <= q_sample;
		slot_s1   <= q_slot;
		ctl_s1    <= q_ctl;
		slot_s2   <= slot_s1;
		sum_s2    <= sum;
		ctl_s2    <= ctl_s1;
		prod_s3   <= sum_s2 * $signed({1'b0, scale_recip});
		ctl_s3    <= ctl_s2;
	end

	assign out_push = v_s3 && ctl_s3.emit;

	ap2d_fifo #(
		.WIDTH(OW),
		.DEPTH(OUT_DEPTH)
	) u_out_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (out_push),
		.wdata ({avg_sat, ctl_s3.plane_done, ctl_s3.job_done}),
		.pop   (pop),
		.rdata (out_rdata),
		.empty (empty),
		.full  (),
		.count (out_count)
	);

	assign average    = $signed(out_rdata[OW-1:2]);
	assign plane_done = out_rdata[1];
	assign job_done   = out_rdata[0];

endmodule

// ----- src/avg_pool_2d_forward.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avg_pool_2d_forward
// Non-overlapping 2-D average pooling over raster-ordered sample planes.
// ----------------------------------------------------------------------------
// Takes one sample per cycle while the input queue is not full: each sample
// costs a single read-modify-write of its column partial sum in the line
// store, with the previous beat's write bypassed so back-to-back hits on one
// column are exact. The sample that closes a window passes line-store read,
// accumulate, multiply and round/saturate before its result is queued.
// The back end only draws from the 4-entry input queue while the 8-entry
// result queue can hold everything in flight, so a stalled consumer backs
// samples up into full without loss. The line store has no reset; windows at
// the right and bottom edges that are cut off count missing pixels as zero
// and use the full-window reciprocal. Configure only with the block drained.
// ----------------------------------------------------------------------------
module avg_pool_2d_forward #(
	parameter int MAX_WIDTH   = ap2d_pkg::MAX_WIDTH_DEF,
	parameter int MAX_WINDOW  = ap2d_pkg::MAX_WINDOW_DEF,
	parameter int SAMPLE_BITS = ap2d_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  push,
	output logic                                  full,
	input  logic signed [SAMPLE_BITS-1:0]         sample,
	output logic                                  empty,
	input  logic                                  pop,
	output logic signed [SAMPLE_BITS-1:0]         average,
	output logic                                  plane_done,
	output logic                                  job_done,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [ap2d_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [ap2d_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
	import ap2d_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int QW = SAMPLE_BITS + CW + CTL_BITS;

	geom_t                   geom_q;
	logic [SCALE_BITS-1:0]   scale_q;

	logic                          accept;
	logic [CW-1:0]                 f_slot;
	ctl_t                          f_ctl;
	logic [QW-1:0]                 q_rdata;
	logic                          q_empty, q_valid, q_pop;
	logic signed [SAMPLE_BITS-1:0] q_sample;
	logic [CW-1:0]                 q_slot;
	ctl_t                          q_ctl;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			geom_q.image_width   <= IMG_W_RST;
			geom_q.image_height  <= IMG_H_RST;
			geom_q.window_width  <= WIN_W_RST;
			geom_q.window_height <= WIN_H_RST;
			geom_q.plane_total   <= PLANE_T_RST;
			scale_q              <= SCALE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_IMAGE_WIDTH: begin
					geom_q.image_width <= cfg_data[IMG_W_BITS-1:0];
				end
				CFG_IMAGE_HEIGHT: begin
					geom_q.image_height <= cfg_data[IMG_H_BITS-1:0];
				end
				CFG_WINDOW_WIDTH: begin
					geom_q.window_width <= cfg_data[WIN_BITS-1:0];
				end
				CFG_WINDOW_HEIGHT: begin
					geom_q.window_height <= cfg_data[WIN_BITS-1:0];
				end
				CFG_SCALE_RECIP: begin
					scale_q <= cfg_data[SCALE_BITS-1:0];
				end
				CFG_PLANE_TOTAL: begin
					geom_q.plane_total <= cfg_data[PLANE_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign accept = push && !full;

	ap2d_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_WINDOW(MAX_WINDOW)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.take  (accept),
		.geom  (geom_q),
		.slot  (f_slot),
		.ctl   (f_ctl)
	);

	ap2d_fifo #(
		.WIDTH(QW),
		.DEPTH(MID_DEPTH)
	) u_mid_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (accept),
		.wdata ({sample, f_slot, f_ctl}),
		.pop   (q_pop),
		.rdata (q_rdata),
		.empty (q_empty),
		.full  (full),
		.count ()
	);

	assign q_valid  = !q_empty;
	assign q_sample = $signed(q_rdata[QW-1 -: SAMPLE_BITS]);
	assign q_slot   = q_rdata[CTL_BITS +: CW];
	assign q_ctl    = ctl_t'(q_rdata[CTL_BITS-1:0]);

	ap2d_back #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_WINDOW (MAX_WINDOW),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_sample   (q_sample),
		.q_slot     (q_slot),
		.q_ctl      (q_ctl),
		.q_pop      (q_pop),
		.scale_recip(scale_q),
		.empty      (empty),
		.pop        (pop),
		.average    (average),
		.plane_done (plane_done),
		.job_done   (job_done)
	);

	// a job ends only on a plane end
	a_job_implies_plane: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && job_done |-> plane_done)
		else $error("job_done without plane_done");

	// back end never draws from an empty queue
	a_pop_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("back end popped an empty queue");

	// an accepted beat is visible to the back end on the next cycle
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> q_valid)
		else $error("accepted sample missing from queue");

endmodule

// ----- test/avg_pool_2d_forward_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avg_pool_2d_forward_tb
// Self-checking bench for the 2-D average pooling block.
// ----------------------------------------------------------------------------
// Streams sample planes through the queue-style ports while a cycle-level
// pooling predictor tracks window sums, row/plane position and job progress.
// Every popped beat is compared against the oldest predicted result. Covers
// register edge values, rounding ties, saturation, cut-off windows, plane
// totals changed between planes, random geometries and full-size planes,
// with random back-pressure on both sides.
// ----------------------------------------------------------------------------
module avg_pool_2d_forward_tb;
	import ap2d_pkg::*;

	localparam int SB = SAMPLE_BITS_DEF;
	localparam logic signed [SB-1:0] SAMPLE_MAX = {1'b0, {(SB-1){1'b1}}};
	localparam logic signed [SB-1:0] SAMPLE_MIN = {1'b1, {(SB-1){1'b0}}};
	localparam longint AVG_MAX = (64'sd1 <<< (SB - 1)) - 1;
	localparam longint AVG_MIN = -AVG_MAX - 1;
	localparam int unsigned IMG_H_LIMIT = (1 << IMG_H_BITS) - 1;
	localparam int unsigned PLANE_LIMIT = (1 << PLANE_BITS) - 1;
	localparam int unsigned UNITY_SCALE = 1 << FRAC_BITS;
	localparam int unsigned SCALE_TOP = (1 << SCALE_BITS) - 1;
	// indexes past the register list, writes must be dropped
	localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_HI = 3'd7;
	// settle margin: a result passes the back-end stages, behind up to 4 queued samples
	localparam int SETTLE_CYCLES = 32;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int MAX_REPORTS = 100;

	typedef struct {
		logic signed [SB-1:0] average;
		logic                 plane_done;
		logic                 job_done;
	} pooled_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     push = 1'b0;
	logic                     full;
	logic signed [SB-1:0]     sample = '0;
	logic                     empty;
	logic                     pop = 1'b0;
	logic signed [SB-1:0]     average;
	logic                     plane_done;
	logic                     job_done;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;

	// predictor registers and position state
	logic [IMG_W_BITS-1:0] img_w_reg = IMG_W_RST;
	logic [IMG_H_BITS-1:0] img_h_reg = IMG_H_RST;
	logic [WIN_BITS-1:0]   win_w_reg = WIN_W_RST;
	logic [WIN_BITS-1:0]   win_h_reg = WIN_H_RST;
	logic [SCALE_BITS-1:0] scale_reg = SCALE_RST;
	logic [PLANE_BITS-1:0] plane_total_reg = PLANE_T_RST;
	longint                col_sum [MAX_WIDTH_DEF];
	int unsigned           col_pos, col_in_win, out_col, row_pos, row_in_win, plane_idx;

	pooled_t     pooled_q [$];
	int unsigned send_idle_pct = 14;
	int unsigned recv_idle_pct = 77;
	int unsigned samples_in, results_checked, cfg_writes, setups, errors;
	int unsigned stall_cycles;

	avg_pool_2d_forward u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.sample     (sample),
		.empty      (empty),
		.pop        (pop),
		.average    (average),
		.plane_done (plane_done),
		.job_done   (job_done),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #2 clk = ~clk;

	// zero acts as 1, above hi acts as hi
	function automatic int unsigned fit_limit(input int unsigned v, input int unsigned hi);
		if (v == 0) begin
			return 1;
		end
		return (v > hi) ? hi : v;
	endfunction

	function automatic int unsigned recip_for(input int unsigned ww, input int unsigned wh);
		int unsigned area;
		area = fit_limit(ww, MAX_WINDOW_DEF) * fit_limit(wh, MAX_WINDOW_DEF);
		return (UNITY_SCALE + area / 2) / area;
	endfunction

	function automatic void apply_cfg(input logic [CFG_IDX_BITS-1:0] idx,
		input logic [CFG_DATA_BITS-1:0] d);
		case (idx)
			CFG_IMAGE_WIDTH:   img_w_reg = d[IMG_W_BITS-1:0];
			CFG_IMAGE_HEIGHT:  img_h_reg = d[IMG_H_BITS-1:0];
			CFG_WINDOW_WIDTH:  win_w_reg = d[WIN_BITS-1:0];
			CFG_WINDOW_HEIGHT: win_h_reg = d[WIN_BITS-1:0];
			CFG_SCALE_RECIP:   scale_reg = d[SCALE_BITS-1:0];
			CFG_PLANE_TOTAL:   plane_total_reg = d[PLANE_BITS-1:0];
			default: ;
		endcase
	endfunction

	// one accepted sample: update the column sum, predict a result if the window closes
	function automatic void pool_step(input logic signed [SB-1:0] s);
		int unsigned iw, ih, ww, wh, pt, slot;
		bit          last_cw, last_c, last_rw, last_r;
		longint      scaled;
		pooled_t     r;
		iw = fit_limit(img_w_reg, MAX_WIDTH_DEF);
		ih = fit_limit(img_h_reg, IMG_H_LIMIT);
		ww = fit_limit(win_w_reg, MAX_WINDOW_DEF);
		wh = fit_limit(win_h_reg, MAX_WINDOW_DEF);
		pt = fit_limit(plane_total_reg, PLANE_LIMIT);
		slot = out_col % MAX_WIDTH_DEF;
		last_cw = (col_in_win + 1 >= ww);
		last_c = (col_pos + 1 >= iw);
		last_rw = (row_in_win + 1 >= wh);
		last_r = (row_pos + 1 >= ih);
		if (row_in_win == 0 && col_in_win == 0) begin
			col_sum[slot] = s;
		end else begin
			col_sum[slot] += s;
		end
		if ((last_cw || last_c) && (last_rw || last_r)) begin
			scaled = (col_sum[slot] * longint'(scale_reg) + 64'sd32768) >>> FRAC_BITS;
			if (scaled > AVG_MAX) begin
				scaled = AVG_MAX;
			end else if (scaled < AVG_MIN) begin
				scaled = AVG_MIN;
			end
			r.average = scaled[SB-1:0];
			r.plane_done = last_c && last_r;
			r.job_done = last_c && last_r && (plane_idx + 1 >= pt);
			pooled_q.push_back(r);
		end
		if (last_c) begin
			col_pos = 0;
			col_in_win = 0;
			out_col = 0;
			if (last_r) begin
				row_pos = 0;
				row_in_win = 0;
				plane_idx = (plane_idx + 1 >= pt) ? 0 : plane_idx + 1;
			end else begin
				row_pos++;
				row_in_win = last_rw ? 0 : row_in_win + 1;
			end
		end else begin
			col_pos++;
			if (last_cw) begin
				col_in_win = 0;
				out_col++;
			end else begin
				col_in_win++;
			end
		end
	endfunction

	function automatic void field_check(input string name, input longint want, input longint got);
		if (want != got) begin
			errors++;
			if (errors <= MAX_REPORTS) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			end
		end
	endfunction

	// monitor: register writes, accepted samples, popped results
	always @(posedge clk) begin
		pooled_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				apply_cfg(cfg_index, cfg_data);
			end
			if (push && !full) begin
				pool_step(sample);
				samples_in++;
			end
			if (pop && !empty) begin
				if (pooled_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected result beat, average %0d plane_done %0b job_done %0b",
						$time, average, plane_done, job_done);
				end else begin
					want = pooled_q.pop_front();
					field_check("average", want.average, average);
					field_check("plane_done", want.plane_done, plane_done);
					field_check("job_done", want.job_done, job_done);
					results_checked++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog, no beat for %0d cycles, %0d results outstanding",
				$time, stall_cycles, pooled_q.size());
			$display("avg_pool_2d_forward_tb NOT OK");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	function automatic logic signed [SB-1:0] pick_sample();
		case ($urandom_range(9))
			0: return SAMPLE_MAX;
			1: return SAMPLE_MIN;
			2: return SB'($urandom_range(16) - 8);
			default: return SB'($urandom);
		endcase
	endfunction

	// random bits above the register field, which the block must drop
	function automatic logic [CFG_DATA_BITS-1:0] with_junk(input int unsigned v, input int bits);
		logic [CFG_DATA_BITS-1:0] d;
		d = CFG_DATA_BITS'($urandom);
		for (int b = 0; b < bits; b++) begin
			d[b] = v[b];
		end
		return d;
	endfunction

	task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
	endtask

	task automatic send_sample(input logic signed [SB-1:0] s);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			sample <= SB'($urandom);
			@(posedge clk);
		end
		push <= 1'b1;
		sample <= s;
		@(posedge clk);
		while (full) begin
			@(posedge clk);
		end
	endtask

	// wait until every predicted result has been popped and the pipe is empty
	task automatic settle_block();
		push <= 1'b0;
		@(posedge clk);
		while (pooled_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// caller lowers cfg_valid after its last write
	task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx,
		input logic [CFG_DATA_BITS-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		cfg_writes++;
	endtask

	task automatic configure(input int unsigned iw, input int unsigned ih, input int unsigned ww,
		input int unsigned wh, input int unsigned sc, input int unsigned pt);
		settle_block();
		cfg_write(CFG_IMAGE_WIDTH, with_junk(iw, IMG_W_BITS));
		cfg_write(CFG_IMAGE_HEIGHT, with_junk(ih, IMG_H_BITS));
		cfg_write(CFG_WINDOW_WIDTH, with_junk(ww, WIN_BITS));
		cfg_write(CFG_WINDOW_HEIGHT, with_junk(wh, WIN_BITS));
		cfg_write(CFG_SCALE_RECIP, with_junk(sc, SCALE_BITS));
		cfg_write(CFG_PLANE_TOTAL, with_junk(pt, PLANE_BITS));
		cfg_valid <= 1'b0;
		setups++;
	endtask

	// 2x2 plane, 2x2 window, one plane per job, straight out of reset
	task automatic test_reset_values();
		repeat (4) send_sample(SAMPLE_MAX);
		repeat (4) send_sample(SAMPLE_MIN);
	endtask

	// zero sizes act as 1, unity scale passes samples through, spare indexes ignored
	task automatic test_register_edges();
		configure(0, 0, 0, 0, UNITY_SCALE, 0);
		@(posedge clk);
		cfg_write(CFG_SPARE_LO, CFG_DATA_BITS'($urandom));
		cfg_write(CFG_SPARE_HI, CFG_DATA_BITS'($urandom));
		cfg_valid <= 1'b0;
		send_sample(SB'(1));
		send_sample(SB'(-1));
		send_sample(SAMPLE_MAX);
		send_sample(SAMPLE_MIN);
	endtask

	// half-way ties round upward; oversized scale saturates; zero scale gives zero
	task automatic test_rounding();
		configure(1, 1, 1, 1, UNITY_SCALE / 2, 1);
		send_sample(SB'(1));
		send_sample(SB'(-1));
		send_sample(SB'(3));
		send_sample(SB'(-3));
		configure(1, 1, 1, 1, SCALE_TOP, 1);
		send_sample(SAMPLE_MAX);
		send_sample(SAMPLE_MIN);
		configure(1, 1, 1, 1, 0, 1);
		send_sample(SAMPLE_MAX);
	endtask

	// 3x1 plane under a 2x2 window: right and bottom windows cut off, two planes per job
	task automatic test_partial_windows();
		configure(3, 1, 2, 2, recip_for(2, 2), 2);
		repeat (6) send_sample(pick_sample());
	endtask

	// scale changes between the rows of one window row; geometry is untouched
	task automatic test_scale_mid_plane();
		configure(4, 2, 2, 2, recip_for(2, 2), 1);
		repeat (4) send_sample(pick_sample());
		settle_block();
		cfg_write(CFG_SCALE_RECIP, with_junk(UNITY_SCALE / 8, SCALE_BITS));
		cfg_valid <= 1'b0;
		repeat (4) send_sample(pick_sample());
	endtask

	task automatic test_random_planes(input int unsigned budget);
		int unsigned sent, iw, ih, ww, wh, sc, pt, planes, n, pt_cap;
		sent = 0;
		while (sent < budget) begin
			if (sent < budget / 3) begin
				set_idling(14, 77);
			end else if (sent < 2 * budget / 3) begin
				set_idling(77, 14);
			end else begin
				set_idling(0, 0);
			end
			iw = ($urandom_range(7) == 0) ? $urandom_range(17, 64) : $urandom_range(0, 16);
			ih = $urandom_range(0, (iw > 16) ? 3 : 10);
			ww = ($urandom_range(9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
			wh = ($urandom_range(9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
			sc = ($urandom_range(3) == 0) ? $urandom_range(0, SCALE_TOP) : recip_for(ww, wh);
			pt = $urandom_range(0, 4);
			// fewer planes than the total leaves the job open for the next setup
			pt_cap = fit_limit(pt, PLANE_LIMIT);
			planes = $urandom_range(1, (pt_cap > 3) ? 3 : pt_cap);
			configure(iw, ih, ww, wh, sc, pt);
			n = fit_limit(iw, MAX_WIDTH_DEF) * fit_limit(ih, IMG_H_LIMIT) * planes;
			repeat (n) send_sample(pick_sample());
			sent += n;
		end
	endtask

	// widest plane (oversized width clamps) and a tall single-column plane
	task automatic test_large_planes();
		set_idling(0, 0);
		configure((1 << IMG_W_BITS) - 1, 1, (1 << WIN_BITS) - 1, 0, recip_for(8, 8), 1);
		repeat (MAX_WIDTH_DEF) send_sample(pick_sample());
		configure(0, 204, 0, 8, recip_for(1, 8), 1);
		repeat (204) send_sample(pick_sample());
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_idling(14, 77);
		test_reset_values();
		test_register_edges();
		test_rounding();
		test_partial_windows();
		test_scale_mid_plane();
		test_random_planes(340);
		test_large_planes();
		settle_block();
		$display("Ran %0d samples over %0d register setups (%0d writes): edge registers,",
			samples_in, setups, cfg_writes);
		$display("rounding, saturation, cut-off windows, random and full-size planes;");
		$display("%0d results, %0d errors", results_checked, errors);
		if (errors == 0) begin
			$display("avg_pool_2d_forward_tb OK");
		end else begin
			$display("avg_pool_2d_forward_tb NOT OK");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
src/ap2d_pkg.sv
src/ap2d_ram.sv
src/ap2d_fifo.sv
src/ap2d_front.sv
src/ap2d_back.sv
src/avg_pool_2d_forward.sv
test/avg_pool_2d_forward_tb.sv
